@@ rtl/core/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assertion macros
// concurrent checks, present in simulation and empty in synthesis
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// property must hold at every clock edge outside reset
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// expression must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg)
`endif

`endif

@@ rtl/core/nbt_pkg.sv @@
// ----------------------------------------------------------------------------
// nbt_pkg
// types and constants of the block transform
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package nbt_pkg;

	localparam int DEF_BLOCKS    = 32;
	localparam int DEF_BLOCK_LEN = 16;

	localparam int ACTION_W   = 2;
	localparam int INDEX_W    = 9;
	localparam int COEFF_W    = 56;
	localparam int VALUE_W    = 64;
	localparam int IN_TDATA_W = 72;

	localparam logic [ACTION_W-1:0] ACT_WRITE = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_RUN   = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_READ  = 2'd2;

	// divider retires this many quotient bits per cycle
	localparam int DIV_BITS = 4;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ,
		ST_SW_NEXT,
		ST_SW_ROT,
		ST_SW_P2I,
		ST_SW_R2P,
		ST_BF_NEXT,
		ST_BF_ROT,
		ST_BF_ADD,
		ST_DIV_RD,
		ST_DIV_LD,
		ST_DIV_IT,
		ST_DIV_WR
	} state_t;

endpackage

@@ rtl/core/nussbaumer_block_transform.sv @@
// ----------------------------------------------------------------------------
// nussbaumer_block_transform
// in-place radix-2 block transform over polynomials mod x^K+1
// ----------------------------------------------------------------------------
// The store holds BLOCKS blocks of BLOCK_LEN signed 64-bit coefficients in one
// synchronous memory, with a BLOCK_LEN-entry scratch memory for the twiddled
// block. After reset a clearing pass zeroes the store, one entry per cycle,
// before the first item is taken. A write is done as it is taken; a read
// passes through the read state before the next item is taken. A run takes a
// bit-reversal pass that swaps each block pair through scratch, then per
// butterfly a set-up step, a rotation of the upper block into scratch, and
// the sum and difference sharing the single write port, and in inverse mode
// a division pass over every coefficient on a 4-bit-per-cycle divider.
// The single read and single write port of the store serialize these steps.
`timescale 1ns / 1ps

`include "assert_macros.svh"

module nussbaumer_block_transform #(
	parameter int BLOCKS    = nbt_pkg::DEF_BLOCKS,
	parameter int BLOCK_LEN = nbt_pkg::DEF_BLOCK_LEN
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// configuration: inverse_mode
	input  logic                            cfg_we,
	input  logic                            cfg_wdata,
	// input stream
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [nbt_pkg::IN_TDATA_W-1:0]  s_tdata,   // index[8:0], coeff[64:9], zero pad
	input  logic [nbt_pkg::ACTION_W-1:0]    s_tuser,   // action[1:0]
	// output stream
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [nbt_pkg::VALUE_W-1:0]     m_tdata    // value[63:0]
);

	localparam int STORE     = BLOCKS * BLOCK_LEN;
	localparam int AW        = $clog2(STORE);
	localparam int BW        = $clog2(BLOCKS);
	// butterfly levels: block pairs up to len <= BLOCKS
	localparam int NL        = $clog2(BLOCKS + 1) - 1;
	localparam int IW        = BW + 2;
	localparam int KW        = (BLOCK_LEN > 1) ? $clog2(BLOCK_LEN) : 1;
	localparam int TWO_K     = 2 * BLOCK_LEN;
	localparam int SW        = $clog2(TWO_K);
	localparam int TW        = SW + 1;
	localparam int CW        = $clog2(2 * BLOCK_LEN + 1);
	localparam int LW        = $clog2(BW + 2);
	localparam int DW        = $clog2(BLOCKS + 1);
	localparam int VW        = nbt_pkg::VALUE_W;
	localparam int DIV_ITERS = VW / nbt_pkg::DIV_BITS;
	localparam int DCW       = $clog2(DIV_ITERS);
	localparam int ROOT_F    = TWO_K / BLOCKS;
	localparam int ROOT_I    = TWO_K - ROOT_F;

	// payload unpack
	logic [nbt_pkg::INDEX_W-1:0]  in_index;
	logic [nbt_pkg::COEFF_W-1:0]  in_coeff;
	logic [nbt_pkg::ACTION_W-1:0] in_action;
	logic [VW-1:0]                in_coeff_x;
	logic                         in_range;
	logic                         acc;

	assign in_index   = s_tdata[nbt_pkg::INDEX_W-1:0];
	assign in_coeff   = s_tdata[nbt_pkg::INDEX_W +: nbt_pkg::COEFF_W];
	assign in_action  = s_tuser;
	assign in_coeff_x = {{(VW - nbt_pkg::COEFF_W){in_coeff[nbt_pkg::COEFF_W-1]}}, in_coeff};
	assign in_range   = int'(in_index) < STORE;
	assign acc        = s_tvalid && s_tready;

	// per-stage twiddle step, forward and conjugate root
	logic [SW-1:0] step_f [1:BW];
	logic [SW-1:0] step_i [1:BW];
	for (genvar g = 1; g <= BW; g++) begin : g_step
		localparam int SF = (ROOT_F * (BLOCKS / (1 << g))) % TWO_K;
		localparam int SI = (ROOT_I * (BLOCKS / (1 << g))) % TWO_K;
		assign step_f[g] = SW'(SF);
		assign step_i[g] = SW'(SI);
	end

	function automatic logic [AW-1:0] addr_of(input int blk, input int off);
		addr_of = AW'(blk * BLOCK_LEN + off);
	endfunction

	// registers
	nbt_pkg::state_t state_q, state_d;
	logic [CW-1:0]  step_q;
	logic [IW-1:0]  i_q;
	logic [BW-1:0]  j_q;
	logic [LW-1:0]  lvl_q;
	logic [SW-1:0]  shift_q;
	logic [BW-1:0]  p_q;
	logic [BW-1:0]  ub_q;
	logic [BW-1:0]  vb_q;
	logic [AW-1:0]  n_q;
	logic           inv_q;
	logic           oob_q;
	logic [VW-1:0]  diff_q;
	logic           dneg_q;
	logic [VW-1:0]  quo_q;
	logic [DW-1:0]  rem_q;
	logic [DCW-1:0] dcnt_q;
	logic           m_tvalid_q;
	logic [VW-1:0]  m_tdata_q;

	// memories
	logic [VW-1:0] store_mem [STORE];
	logic [VW-1:0] rot_mem [BLOCK_LEN];
	logic [VW-1:0] rd_q;
	logic [VW-1:0] rot_rd_q;

	logic          st_we;
	logic [AW-1:0] st_wa;
	logic [VW-1:0] st_wd;
	logic [AW-1:0] st_ra;
	logic          rot_we;
	logic [KW-1:0] rot_wa;
	logic [VW-1:0] rot_wd;
	logic [KW-1:0] rot_ra;

	// loop helpers
	logic [BW-1:0] p_rev;
	logic          pair_ok;
	logic [IW-1:0] half;
	logic [IW-1:0] len;
	logic [IW-1:0] vb_cand;
	logic [SW-1:0] step_sel;
	logic [TW-1:0] shift_sum;
	logic [SW-1:0] shift_nx;
	logic          last_j;
	logic          step_k_end;
	logic          step_2k_end;
	logic [KW-1:0] step_k;
	logic [KW-1:0] kprev;
	logic [KW-1:0] khalf;

	always_comb begin
		for (int b = 0; b < BW; b++) begin
			p_rev[b] = i_q[BW-1-b];
		end
	end

	assign pair_ok     = (i_q < IW'(p_rev)) && (int'(p_rev) < BLOCKS);
	assign half        = IW'(1) << (lvl_q - LW'(1));
	assign len         = half << 1;
	assign vb_cand     = i_q + IW'(j_q) + half;
	assign step_sel    = inv_q ? step_i[lvl_q] : step_f[lvl_q];
	assign shift_sum   = TW'(shift_q) + TW'(step_sel);
	assign shift_nx    = (shift_sum >= TW'(TWO_K)) ? SW'(shift_sum - TW'(TWO_K)) : SW'(shift_sum);
	assign last_j      = (IW'(j_q) + IW'(1)) == half;
	assign step_k_end  = step_q == CW'(BLOCK_LEN);
	assign step_2k_end = step_q == CW'(TWO_K);
	assign step_k      = KW'(step_q);
	assign kprev       = KW'(step_q - CW'(1));
	assign khalf       = KW'(step_q >> 1);

	// rotation of a block into scratch by x^shift, sign flip on wrap
	logic [BW-1:0] rot_blk;
	logic [SW-1:0] rot_sh;
	logic          flip;
	logic [SW-1:0] rot_r;
	logic [TW-1:0] src_t;
	logic [KW-1:0] src_k;
	logic          rot_neg;

	assign rot_blk = (state_q == nbt_pkg::ST_SW_ROT) ? i_q[BW-1:0] : vb_q;
	assign rot_sh  = (state_q == nbt_pkg::ST_SW_ROT) ? '0 : shift_q;
	assign flip    = rot_sh >= SW'(BLOCK_LEN);
	assign rot_r   = flip ? SW'(rot_sh - SW'(BLOCK_LEN)) : rot_sh;
	assign src_t   = TW'(step_k) + TW'(BLOCK_LEN) - TW'(rot_r);
	assign src_k   = (src_t >= TW'(BLOCK_LEN)) ? KW'(src_t - TW'(BLOCK_LEN)) : KW'(src_t);
	assign rot_neg = flip ^ (SW'(kprev) < rot_r);

	// divider, several restoring steps a cycle
	logic [VW-1:0] quo_nx;
	logic [DW-1:0] rem_nx;
	always_comb begin
		logic [DW:0] remx;
		quo_nx = quo_q;
		rem_nx = rem_q;
		for (int s = 0; s < nbt_pkg::DIV_BITS; s++) begin
			remx   = {rem_nx, quo_nx[VW-1]};
			quo_nx = quo_nx << 1;
			if (remx >= (DW + 1)'(BLOCKS)) begin
				remx      = remx - (DW + 1)'(BLOCKS);
				quo_nx[0] = 1'b1;
			end
			rem_nx = remx[DW-1:0];
		end
	end

	// next state and memory strobes
	always_comb begin
		state_d  = state_q;
		s_tready = 1'b0;
		st_we    = 1'b0;
		st_wa    = '0;
		st_wd    = '0;
		st_ra    = '0;
		rot_we   = 1'b0;
		rot_wa   = '0;
		rot_wd   = '0;
		rot_ra   = '0;
		unique case (state_q)
			nbt_pkg::ST_CLEAR: begin
				st_we = 1'b1;
				st_wa = n_q;
				if (int'(n_q) == STORE - 1) state_d = nbt_pkg::ST_IDLE;
			end
			nbt_pkg::ST_IDLE: begin
				// output slot is free by the time a read lands in it
				s_tready = !m_tvalid_q || m_tready;
				st_ra    = AW'(in_index);
				if (acc) begin
					priority case (in_action)
						nbt_pkg::ACT_WRITE: begin
							st_we = in_range;
							st_wa = AW'(in_index);
							st_wd = in_coeff_x;
						end
						nbt_pkg::ACT_RUN:  state_d = nbt_pkg::ST_SW_NEXT;
						nbt_pkg::ACT_READ: state_d = nbt_pkg::ST_READ;
						default: ;
					endcase
				end
			end
			nbt_pkg::ST_READ: state_d = nbt_pkg::ST_IDLE;
			nbt_pkg::ST_SW_NEXT: begin
				if (i_q == IW'(BLOCKS)) state_d = nbt_pkg::ST_BF_NEXT;
				else if (pair_ok)       state_d = nbt_pkg::ST_SW_ROT;
			end
			nbt_pkg::ST_SW_ROT, nbt_pkg::ST_BF_ROT: begin
				st_ra = addr_of(int'(rot_blk), int'(src_k));
				if (step_q != '0) begin
					rot_we = 1'b1;
					rot_wa = kprev;
					rot_wd = rot_neg ? VW'(0) - rd_q : rd_q;
				end
				if (step_k_end) begin
					state_d = (state_q == nbt_pkg::ST_SW_ROT) ? nbt_pkg::ST_SW_P2I
						: nbt_pkg::ST_BF_ADD;
				end
			end
			nbt_pkg::ST_SW_P2I: begin
				st_ra = addr_of(int'(p_q), int'(step_k));
				if (step_q != '0) begin
					st_we = 1'b1;
					st_wa = addr_of(int'(i_q), int'(kprev));
					st_wd = rd_q;
				end
				if (step_k_end) state_d = nbt_pkg::ST_SW_R2P;
			end
			nbt_pkg::ST_SW_R2P: begin
				rot_ra = step_k;
				if (step_q != '0) begin
					st_we = 1'b1;
					st_wa = addr_of(int'(p_q), int'(kprev));
					st_wd = rot_rd_q;
				end
				if (step_k_end) state_d = nbt_pkg::ST_SW_NEXT;
			end
			nbt_pkg::ST_BF_NEXT: begin
				if (lvl_q > LW'(NL)) begin
					state_d = inv_q ? nbt_pkg::ST_DIV_RD : nbt_pkg::ST_IDLE;
				end else if (i_q < IW'(BLOCKS) && vb_cand < IW'(BLOCKS)) begin
					state_d = nbt_pkg::ST_BF_ROT;
				end
			end
			nbt_pkg::ST_BF_ADD: begin
				if (!step_q[0]) begin
					if (!step_2k_end) begin
						st_ra  = addr_of(int'(ub_q), int'(khalf));
						rot_ra = khalf;
					end
					if (step_q != '0) begin
						st_we = 1'b1;
						st_wa = addr_of(int'(vb_q), int'(step_q >> 1) - 1);
						st_wd = diff_q;
					end
				end else begin
					st_we = 1'b1;
					st_wa = addr_of(int'(ub_q), int'(khalf));
					st_wd = rd_q + rot_rd_q;
				end
				if (step_2k_end) state_d = nbt_pkg::ST_BF_NEXT;
			end
			nbt_pkg::ST_DIV_RD: begin
				st_ra   = n_q;
				state_d = nbt_pkg::ST_DIV_LD;
			end
			nbt_pkg::ST_DIV_LD: state_d = nbt_pkg::ST_DIV_IT;
			nbt_pkg::ST_DIV_IT: begin
				if (dcnt_q == DCW'(DIV_ITERS - 1)) state_d = nbt_pkg::ST_DIV_WR;
			end
			nbt_pkg::ST_DIV_WR: begin
				st_we   = 1'b1;
				st_wa   = n_q;
				st_wd   = dneg_q ? VW'(0) - quo_q : quo_q;
				state_d = (int'(n_q) == STORE - 1) ? nbt_pkg::ST_IDLE : nbt_pkg::ST_DIV_RD;
			end
			default: state_d = nbt_pkg::ST_IDLE;
		endcase
	end

	// store and scratch memories
	always_ff @(posedge clk) begin
		if (st_we) store_mem[st_wa] <= st_wd;
		rd_q <= store_mem[st_ra];
	end

	always_ff @(posedge clk) begin
		if (rot_we) rot_mem[rot_wa] <= rot_wd;
		rot_rd_q <= rot_mem[rot_ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= nbt_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// loop counters and control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q     <= '0;
			i_q        <= '0;
			j_q        <= '0;
			lvl_q      <= '0;
			shift_q    <= '0;
			n_q        <= '0;
			inv_q      <= 1'b0;
			dcnt_q     <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cfg_we) inv_q <= cfg_wdata;

			if (state_q == nbt_pkg::ST_READ) m_tvalid_q <= 1'b1;
			else if (m_tready)               m_tvalid_q <= 1'b0;

			unique case (state_q)
				nbt_pkg::ST_CLEAR: begin
					n_q <= (int'(n_q) == STORE - 1) ? '0 : n_q + AW'(1);
				end
				nbt_pkg::ST_IDLE: begin
					if (acc && in_action == nbt_pkg::ACT_RUN) i_q <= IW'(1);
				end
				nbt_pkg::ST_SW_NEXT: begin
					if (i_q == IW'(BLOCKS)) begin
						i_q     <= '0;
						j_q     <= '0;
						lvl_q   <= LW'(1);
						shift_q <= '0;
					end else if (!pair_ok) begin
						i_q <= i_q + IW'(1);
					end
				end
				nbt_pkg::ST_SW_ROT, nbt_pkg::ST_SW_P2I, nbt_pkg::ST_BF_ROT: begin
					step_q <= step_k_end ? '0 : step_q + CW'(1);
				end
				nbt_pkg::ST_SW_R2P: begin
					step_q <= step_k_end ? '0 : step_q + CW'(1);
					if (step_k_end) i_q <= i_q + IW'(1);
				end
				nbt_pkg::ST_BF_NEXT: begin
					if (lvl_q <= LW'(NL)) begin
						if (i_q >= IW'(BLOCKS)) begin
							lvl_q   <= lvl_q + LW'(1);
							i_q     <= '0;
							j_q     <= '0;
							shift_q <= '0;
						end else if (vb_cand >= IW'(BLOCKS)) begin
							// upper block missing: skip the butterfly
							if (last_j) begin
								j_q     <= '0;
								i_q     <= i_q + len;
								shift_q <= '0;
							end else begin
								j_q     <= j_q + BW'(1);
								shift_q <= shift_nx;
							end
						end
					end
				end
				nbt_pkg::ST_BF_ADD: begin
					step_q <= step_2k_end ? '0 : step_q + CW'(1);
					if (step_2k_end) begin
						if (last_j) begin
							j_q     <= '0;
							i_q     <= i_q + len;
							shift_q <= '0;
						end else begin
							j_q     <= j_q + BW'(1);
							shift_q <= shift_nx;
						end
					end
				end
				nbt_pkg::ST_DIV_LD: dcnt_q <= '0;
				nbt_pkg::ST_DIV_IT: dcnt_q <= dcnt_q + DCW'(1);
				nbt_pkg::ST_DIV_WR: begin
					n_q <= (int'(n_q) == STORE - 1) ? '0 : n_q + AW'(1);
				end
				default: ;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (state_q == nbt_pkg::ST_IDLE && acc) oob_q <= !in_range;
		if (state_q == nbt_pkg::ST_READ) m_tdata_q <= oob_q ? '0 : rd_q;
		if (state_q == nbt_pkg::ST_SW_NEXT) p_q <= p_rev;
		if (state_q == nbt_pkg::ST_BF_NEXT) begin
			ub_q <= BW'(i_q + IW'(j_q));
			vb_q <= BW'(vb_cand);
		end
		if (state_q == nbt_pkg::ST_BF_ADD && step_q[0]) diff_q <= rd_q - rot_rd_q;
		if (state_q == nbt_pkg::ST_DIV_LD) begin
			dneg_q <= rd_q[VW-1];
			quo_q  <= rd_q[VW-1] ? VW'(0) - rd_q : rd_q;
			rem_q  <= '0;
		end else if (state_q == nbt_pkg::ST_DIV_IT) begin
			quo_q <= quo_nx;
			rem_q <= rem_nx;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	`ASSERT_PROP(a_ready_idle, clk, arst_n, s_tready |-> state_q == nbt_pkg::ST_IDLE, "ready outside idle")
	`ASSERT_PROP(a_read_result, clk, arst_n, (acc && in_action == nbt_pkg::ACT_READ) |=> ##1 m_tvalid, "read gave no result")
	`ASSERT_PROP(a_result_src, clk, arst_n, $rose(m_tvalid) |-> $past(state_q) == nbt_pkg::ST_READ, "result without a read")
	`ASSERT_NEVER(a_read_nowrite, clk, arst_n, state_q == nbt_pkg::ST_READ && st_we, "store written during read")

endmodule

@@ test/nbt_checker.sv @@
// ----------------------------------------------------------------------------
// nbt_checker
// predicts the coefficient store and checks every read transfer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module nbt_checker #(
	parameter int BLOCKS    = nbt_pkg::DEF_BLOCKS,
	parameter int BLOCK_LEN = nbt_pkg::DEF_BLOCK_LEN
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic                           cfg_wdata,
	input  logic                           s_tvalid,
	input  logic                           s_tready,
	input  logic [nbt_pkg::IN_TDATA_W-1:0] s_tdata,
	input  logic [nbt_pkg::ACTION_W-1:0]   s_tuser,
	input  logic                           m_tvalid,
	input  logic                           m_tready,
	input  logic [nbt_pkg::VALUE_W-1:0]    m_tdata,
	output int                             errors,
	output int                             pending,
	output int                             reads_done,
	output int                             runs_done
);

	localparam int STORE = BLOCKS * BLOCK_LEN;
	localparam int TWO_K = 2 * BLOCK_LEN;
	localparam int IX_W  = nbt_pkg::INDEX_W;
	localparam int CF_W  = nbt_pkg::COEFF_W;

	logic [63:0] coeff_mirror [STORE];
	logic [63:0] read_values [$];
	logic        inv_mode;

	// in-place transform of the mirrored store
	task automatic transform_store();
		int i, j, k, b, bits, p, len, half, step, root, ub, vb, sh, flip, r, src, neg;
		logic [63:0] t, u, v, mag;
		logic [63:0] rot [BLOCK_LEN];
		bits = 0;
		while ((1 << bits) < BLOCKS)
			bits++;
		for (i = 1; i < BLOCKS; i++) begin
			p = 0;
			for (b = 0; b < bits; b++)
				p = (p << 1) | ((i >> b) & 1);
			if (i < p && p < BLOCKS) begin
				for (k = 0; k < BLOCK_LEN; k++) begin
					t = coeff_mirror[i*BLOCK_LEN+k];
					coeff_mirror[i*BLOCK_LEN+k] = coeff_mirror[p*BLOCK_LEN+k];
					coeff_mirror[p*BLOCK_LEN+k] = t;
				end
			end
		end
		root = TWO_K / BLOCKS;
		if (inv_mode)
			root = TWO_K - root;
		for (len = 2; len <= BLOCKS; len <<= 1) begin
			half = len >> 1;
			step = (root * (BLOCKS / len)) % TWO_K;
			for (i = 0; i < BLOCKS; i += len) begin
				for (j = 0; j < half; j++) begin
					if (i + j + half < BLOCKS) begin
						ub = (i + j) * BLOCK_LEN;
						vb = (i + j + half) * BLOCK_LEN;
						sh = (j * step) % TWO_K;
						flip = (sh >= BLOCK_LEN) ? 1 : 0;
						r = sh - flip * BLOCK_LEN;
						// multiply by x^sh: rotate, negating what wraps
						for (k = 0; k < BLOCK_LEN; k++) begin
							src = (k + BLOCK_LEN - r) % BLOCK_LEN;
							neg = flip ^ ((k < r) ? 1 : 0);
							v = coeff_mirror[vb+src];
							rot[k] = neg ? 64'd0 - v : v;
						end
						for (k = 0; k < BLOCK_LEN; k++) begin
							u = coeff_mirror[ub+k];
							coeff_mirror[ub+k] = u + rot[k];
							coeff_mirror[vb+k] = u - rot[k];
						end
					end
				end
			end
		end
		if (inv_mode) begin
			// divide by block count, truncating toward zero
			for (i = 0; i < STORE; i++) begin
				t = coeff_mirror[i];
				mag = t[63] ? 64'd0 - t : t;
				mag = mag / BLOCKS;
				coeff_mirror[i] = t[63] ? 64'd0 - mag : mag;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		logic [IX_W-1:0] idx;
		logic [63:0]     got, want;
		if (!arst_n) begin
			for (int n = 0; n < STORE; n++)
				coeff_mirror[n] = '0;
			read_values.delete();
			inv_mode = 1'b0;
			errors = 0;
			pending = 0;
			reads_done = 0;
			runs_done = 0;
		end else begin
			if (cfg_we)
				inv_mode = cfg_wdata;
			if (s_tvalid && s_tready) begin
				idx = s_tdata[IX_W-1:0];
				case (s_tuser)
					nbt_pkg::ACT_WRITE: begin
						if (idx < STORE)
							coeff_mirror[idx] = {{8{s_tdata[IX_W+CF_W-1]}},
								s_tdata[IX_W +: CF_W]};
					end
					nbt_pkg::ACT_RUN: begin
						transform_store();
						runs_done++;
					end
					nbt_pkg::ACT_READ: begin
						read_values.push_back((idx < STORE) ? coeff_mirror[idx] : 64'd0);
					end
					default: ;
				endcase
			end
			if (m_tvalid && m_tready) begin
				got = m_tdata;
				if (read_values.size() == 0) begin
					if (errors < 10)
						$display("unexpected result transfer: value %h", got);
					errors++;
				end else begin
					want = read_values.pop_front();
					reads_done++;
					if (got !== want) begin
						if (errors < 10)
							$display("value mismatch: expected %h, got %h", want, got);
						errors++;
					end
				end
			end
			pending = read_values.size();
		end
	end

endmodule

@@ test/tb_nussbaumer_block_transform.sv @@
// ----------------------------------------------------------------------------
// tb_nussbaumer_block_transform
// stream-level test of the block transform against a mirrored store
// ----------------------------------------------------------------------------
// Drives write, run, read and unused-action transfers, first a directed set
// on the coefficient extremes in both modes, then random traffic under four
// idling patterns, with a long output hold-off that backs up the input.
// A separate checker mirrors the store and compares every read.
`timescale 1ns / 1ps

module tb_nussbaumer_block_transform;

	localparam int STORE      = nbt_pkg::DEF_BLOCKS * nbt_pkg::DEF_BLOCK_LEN;
	localparam int DOG_LIMIT  = 100000;
	// longest silent stretch: an inverse run plus its division pass
	localparam int DRAIN_WAIT = 20000;
	localparam int TD_W       = nbt_pkg::IN_TDATA_W;
	localparam int AC_W       = nbt_pkg::ACTION_W;
	localparam int CF_W       = nbt_pkg::COEFF_W;
	localparam int IX_W       = nbt_pkg::INDEX_W;
	localparam logic [AC_W-1:0] ACT_UNUSED = 2'd3;

	logic                       clk;
	logic                       arst_n;
	logic                       cfg_we;
	logic                       cfg_wdata;
	logic                       s_tvalid;
	logic                       s_tready;
	logic [TD_W-1:0]            s_tdata;   // index[8:0], coeff[64:9], zero pad
	logic [AC_W-1:0]            s_tuser;   // action[1:0]
	logic                       m_tvalid;
	logic                       m_tready;
	logic [nbt_pkg::VALUE_W-1:0] m_tdata;  // value[63:0]

	int errors, pending, reads_done, runs_done;
	int quiet_cycles = 0;
	bit tx_idle, rx_stall;
	int idle_pct;
	int hold_seq;

	nussbaumer_block_transform DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	nbt_checker u_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.errors    (errors),
		.pending   (pending),
		.reads_done(reads_done),
		.runs_done (runs_done)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// watchdog: cycles with no transfer on either side
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= DOG_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// receiver: random stalls, plus a long hold-off whenever hold_seq moves
	initial begin
		int seen, hold;
		seen = 0;
		hold = 0;
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_seq != seen) begin
				seen = hold_seq;
				hold = 400;
			end
			if (hold > 0) begin
				hold--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= rx_stall ? ($urandom_range(99) >= idle_pct) : 1'b1;
			end
		end
	end

	// one input transfer, with optional idle cycles ahead of it
	task automatic send_item(logic [AC_W-1:0] act, int idx, logic [CF_W-1:0] c);
		while (tx_idle && $urandom_range(99) < idle_pct) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tuser  <= act;
		s_tdata  <= {7'd0, c, idx[IX_W-1:0]};
		do
			@(posedge clk);
		while (!s_tready);
	endtask

	// drain, let a trailing run finish, then change the mode
	task automatic set_mode(logic m);
		@(negedge clk);
		s_tvalid <= 1'b0;
		wait (pending == 0);
		repeat (DRAIN_WAIT) @(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= m;
		@(negedge clk);
		cfg_we    <= 1'b0;
	endtask

	task automatic random_item();
		int r;
		logic [CF_W-1:0] c;
		r = $urandom_range(99);
		c = CF_W'({$urandom, $urandom});
		// some values stay small so divisions land near zero
		if ($urandom_range(3) == 0)
			c = {{(CF_W-8){c[7]}}, c[7:0]};
		if (r < 2)
			send_item(nbt_pkg::ACT_RUN, $urandom_range(STORE-1), c);
		else if (r < 42)
			send_item(nbt_pkg::ACT_WRITE, $urandom_range(STORE-1), c);
		else if (r < 94)
			send_item(nbt_pkg::ACT_READ, $urandom_range(STORE-1), c);
		else
			send_item(ACT_UNUSED, $urandom_range(STORE-1), c);
	endtask

	localparam logic [CF_W-1:0] C_MAX = {1'b0, {(CF_W-1){1'b1}}};
	localparam logic [CF_W-1:0] C_MIN = {1'b1, {(CF_W-1){1'b0}}};

	initial begin
		arst_n    = 1'b0;
		cfg_we    = 1'b0;
		cfg_wdata = 1'b0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tuser   = nbt_pkg::ACT_WRITE;
		tx_idle   = 1'b0;
		rx_stall  = 1'b0;
		idle_pct  = 58;
		hold_seq  = 0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: extremes, every action, forward then inverse
		set_mode(1'b0);
		send_item(nbt_pkg::ACT_WRITE, 0, C_MAX);
		send_item(nbt_pkg::ACT_WRITE, STORE-1, C_MIN);
		send_item(nbt_pkg::ACT_WRITE, 17, '1);
		send_item(nbt_pkg::ACT_WRITE, 16, 56'd1);
		send_item(nbt_pkg::ACT_WRITE, 255, '0);
		send_item(nbt_pkg::ACT_READ, 0, '0);
		send_item(nbt_pkg::ACT_READ, STORE-1, '1);
		send_item(nbt_pkg::ACT_READ, 17, '0);
		send_item(ACT_UNUSED, 5, C_MAX);
		send_item(nbt_pkg::ACT_RUN, 0, '0);
		send_item(nbt_pkg::ACT_READ, 0, '0);
		send_item(nbt_pkg::ACT_READ, 16, '0);
		send_item(nbt_pkg::ACT_READ, STORE-1, '0);
		set_mode(1'b1);
		send_item(nbt_pkg::ACT_RUN, 0, '0);
		send_item(nbt_pkg::ACT_READ, 0, '0);
		send_item(nbt_pkg::ACT_READ, 17, '0);
		send_item(nbt_pkg::ACT_READ, STORE-1, '0);

		// random phases with alternating mode and idling pattern
		for (int ph = 0; ph < 4; ph++) begin
			set_mode(ph[0]);
			tx_idle  = (ph == 1) || (ph == 3);
			rx_stall = (ph == 2) || (ph == 3);
			idle_pct = (ph == 3) ? 26 : 58;
			if (ph == 0) begin
				// long output hold-off while reads keep coming
				hold_seq++;
				for (int n = 0; n < 60; n++)
					send_item(nbt_pkg::ACT_READ, $urandom_range(STORE-1), '0);
			end
			for (int n = 0; n < 450; n++) begin
				// both-sides phase gets plain stretches as well
				if (ph == 3 && n % 100 == 50) begin
					tx_idle  = ~tx_idle;
					rx_stall = ~rx_stall;
				end
				random_item();
			end
		end

		@(negedge clk);
		s_tvalid <= 1'b0;
		wait (pending == 0);
		repeat (DRAIN_WAIT) @(negedge clk);
		$display("covered %0d checked reads and %0d transforms in both modes", reads_done,
			runs_done);
		if (errors == 0 && pending == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
